// ===== sv/fscm_pkg.sv =====
`default_nettype none
package fscm_pkg;

    localparam int MAX_IDS = 1024;
    localparam int SLOTS   = 16;
    localparam int ID_W    = $clog2(MAX_IDS);
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(SLOTS);

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

endpackage
`default_nettype wire

// ===== sv/fscm_ram.sv =====
`default_nettype none
module fscm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/fscm_victim.sv =====
`default_nettype none
module fscm_victim
    import fscm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cnt_t slots_in_use,
    input  wire logic advance,
    output slot_t     victim
);

    slot_t ptr_reg;
    slot_t ptr_next;
    slot_t victim_next;
    cnt_t  active;
    cnt_t  victim_inc;

    always_comb
    begin
        if (slots_in_use == '0)
        begin
            active = CNT_W'(1);
        end
        else if (slots_in_use > CNT_W'(SLOTS))
        begin
            active = CNT_W'(SLOTS);
        end
        else
        begin
            active = slots_in_use;
        end

        victim      = ({1'b0, ptr_reg} >= active) ? '0 : ptr_reg;
        victim_inc  = {1'b0, victim} + CNT_W'(1);
        victim_next = (victim_inc >= active) ? '0 : victim_inc[SLOT_W-1:0];
        ptr_next    = advance ? victim_next : ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fifo_slot_cache_map_core.sv =====
// An accepted request passes through S_MAP, S_OWN and S_VIC, and its result is registered as
// it leaves S_VIC. A new request is taken only in S_IDLE, once the last one has done the two
// dependent reads of the id map and slot owner memories and the victim owner read before
// write-back. A waiting result sits in the output register while the next request is taken.
// Reset clears the control, owner valid bits and pointer at once, then a clearing pass zeroes
// all 1024 id map entries with the input held off; map entries are checked against owners.
`default_nettype none
module fifo_slot_cache_map_core
    import fscm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire id_t  item_id,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      hit,
    output slot_t     slot,
    output logic      evicted,
    output id_t       evicted_id,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire cnt_t slots_in_use
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_OWN,
        S_VIC
    } state_t;

    state_t            state_reg;
    id_t               clear_idx_reg;
    cnt_t              slots_reg;
    logic [SLOTS-1:0]  own_valid_reg;
    id_t               id_reg;
    slot_t             slot_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    slot_t             out_slot_reg;
    logic              out_evicted_reg;
    id_t               out_evicted_id_reg;

    slot_t map_rdata;
    id_t   own_rdata;
    slot_t own_raddr;
    slot_t victim;
    logic  out_free;
    logic  finish;
    logic  do_write;
    logic  clearing;
    logic  map_we;
    id_t   map_waddr;
    slot_t map_wdata;

    fscm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_IDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (item_id),
        .rdata (map_rdata)
    );

    fscm_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (do_write),
        .waddr (victim),
        .wdata (id_reg),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    fscm_victim u_victim (
        .clk          (clk),
        .rst_n        (rst_n),
        .slots_in_use (slots_reg),
        .advance      (do_write),
        .victim       (victim)
    );

    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        finish    = (state_reg == S_VIC) && out_free;
        do_write  = finish && !hit_reg;
        clearing  = (state_reg == S_CLEAR);
        map_we    = do_write || clearing;
        map_waddr = clearing ? clear_idx_reg : id_reg;
        map_wdata = clearing ? '0 : victim;
        own_raddr = (state_reg == S_MAP) ? map_rdata : victim;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign slot       = out_slot_reg;
    assign evicted    = out_evicted_reg;
    assign evicted_id = out_evicted_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_idx_reg <= '0;
            slots_reg     <= SLOTS_RESET;
            own_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                slots_reg <= slots_in_use;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clear_idx_reg <= clear_idx_reg + id_t'(1);
                    if (clear_idx_reg == id_t'(MAX_IDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    state_reg <= S_OWN;
                end
                S_OWN:
                begin
                    state_reg <= S_VIC;
                end
                S_VIC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (!hit_reg)
                        begin
                            own_valid_reg[victim] <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // hold the request state as it moves through the states; load the beat payload only when the result leaves S_VIC
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            id_reg <= item_id;
        end
        if (state_reg == S_MAP)
        begin
            slot_reg <= map_rdata;
        end
        if (state_reg == S_OWN)
        begin
            hit_reg <= own_valid_reg[slot_reg] && (own_rdata == id_reg);
        end
        if (finish)
        begin
            out_hit_reg <= hit_reg;
            if (hit_reg)
            begin
                out_slot_reg       <= slot_reg;
                out_evicted_reg    <= 1'b0;
                out_evicted_id_reg <= '0;
            end
            else
            begin
                out_slot_reg       <= victim;
                out_evicted_reg    <= own_valid_reg[victim];
                out_evicted_id_reg <= own_valid_reg[victim] ? own_rdata : '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import fscm_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;
    localparam int POOL_SIZE    = 24;

    typedef struct packed {
        logic  hit;
        slot_t slot;
        logic  evicted;
        id_t   evicted_id;
    } lookup_t;

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  in_valid     = 1'b0;
    id_t   item_id      = '0;
    logic  out_ready    = 1'b0;
    logic  cfg_valid    = 1'b0;
    cnt_t  slots_in_use = '0;
    logic  in_ready;
    logic  out_valid;
    logic  hit;
    slot_t slot;
    logic  evicted;
    id_t   evicted_id;
    logic  cfg_ready;

    bit    id_cached  [MAX_IDS];
    slot_t id_slot    [MAX_IDS];
    bit    slot_owned [SLOTS];
    id_t   slot_owner [SLOTS];
    int    victim_ptr     = 0;
    int    slot_count_reg = SLOTS;

    lookup_t expected_lookups [$];
    int      errors    = 0;
    int      cycles    = 0;
    bit      steady    = 1'b0;
    bit      hold_req  = 1'b0;
    int      hold_left = 0;

    fifo_slot_cache_map_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .item_id      (item_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .slot         (slot),
        .evicted      (evicted),
        .evicted_id   (evicted_id),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .slots_in_use (slots_in_use)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver: random idling, steady stretches and one long hold-off
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 8);
    end

    function automatic lookup_t predict_lookup(input id_t id);
        lookup_t r;
        int      n;
        slot_t   s;
        r = '0;
        if (id_cached[id])
        begin
            r.hit  = 1'b1;
            r.slot = id_slot[id];
            return r;
        end
        if (slot_count_reg == 0)
            n = 1;
        else if (slot_count_reg > SLOTS)
            n = SLOTS;
        else
            n = slot_count_reg;
        if (victim_ptr >= n)
            victim_ptr = 0;
        s = slot_t'(victim_ptr);
        if (slot_owned[s])
        begin
            id_cached[slot_owner[s]] = 1'b0;
            r.evicted    = 1'b1;
            r.evicted_id = slot_owner[s];
        end
        id_cached[id] = 1'b1;
        id_slot[id]   = s;
        slot_owned[s] = 1'b1;
        slot_owner[s] = id;
        victim_ptr    = (victim_ptr + 1 >= n) ? 0 : victim_ptr + 1;
        r.slot        = s;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_lookups.size() == 0)
                report_mismatch("result beat with no request outstanding");
            else
            begin
                want = expected_lookups.pop_front();
                if (hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, expected %0b", hit, want.hit));
                if (slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
                if (evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %0b, expected %0b",
                                              evicted, want.evicted));
                if (evicted_id !== want.evicted_id)
                    report_mismatch($sformatf("evicted_id %0d, expected %0d",
                                              evicted_id, want.evicted_id));
            end
        end
    end

    task automatic send_item(input id_t id);
        lookup_t want;
        if (!steady && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        item_id  <= id;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        want = predict_lookup(id);
        expected_lookups = {expected_lookups, want};
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_lookups.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_slot_count(input cnt_t value);
        drain();
        cfg_valid    <= 1'b1;
        slots_in_use <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        slot_count_reg = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_default;
        send_item(id_t'(0));
        send_item(id_t'(MAX_IDS - 1));
        send_item(id_t'(0));
        send_item(id_t'(MAX_IDS - 1));
    endtask

    // a recent hit must not save a slot from replacement
    task automatic test_fifo_order;
        write_slot_count(cnt_t'(2));
        send_item(id_t'(5));
        send_item(id_t'(MAX_IDS - 1));
        send_item(id_t'(7));
        send_item(id_t'(5));
    endtask

    task automatic test_count_extremes;
        write_slot_count(cnt_t'(0));
        send_item(id_t'(9));
        send_item(id_t'(10));
        send_item(id_t'(10));
        write_slot_count(cnt_t'(31));
        send_item(id_t'(11));
        send_item(id_t'(12));
        write_slot_count(cnt_t'(SLOTS + 1));
        send_item(id_t'(13));
    endtask

    // owners of slots beyond a reduced count keep hitting
    task automatic test_count_shrink;
        int i;
        write_slot_count(cnt_t'(SLOTS));
        for (i = 0; i < 6; i++)
            send_item(id_t'(200 + i));
        write_slot_count(cnt_t'(3));
        send_item(id_t'(203));
        send_item(id_t'(205));
        send_item(id_t'(300));
        send_item(id_t'(301));
    endtask

    task automatic test_random_phases;
        int   phase;
        int   k;
        id_t  base;
        id_t  id;
        cnt_t count;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       count = cnt_t'(SLOTS);
                1:       count = cnt_t'(1);
                default: count = cnt_t'($urandom_range(0, 31));
            endcase
            write_slot_count(count);
            steady = (phase == 2);
            base   = id_t'($urandom_range(0, MAX_IDS - 1));
            for (k = 0; k < 90; k++)
            begin
                if ($urandom_range(0, 99) < 65)
                    id = base + id_t'($urandom_range(0, POOL_SIZE - 1));
                else
                    id = id_t'($urandom_range(0, MAX_IDS - 1));
                send_item(id);
            end
            steady = 1'b0;
        end
    endtask

    // hold the result side so the block fills and stalls its input
    task automatic test_backpressure;
        int  k;
        id_t base;
        write_slot_count(cnt_t'($urandom_range(4, SLOTS)));
        base     = id_t'($urandom_range(0, MAX_IDS - 1));
        hold_req = 1'b1;
        steady   = 1'b1;
        for (k = 0; k < 40; k++)
            send_item(base + id_t'($urandom_range(0, POOL_SIZE - 1)));
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_default();
        test_fifo_order();
        test_count_extremes();
        test_count_shrink();
        test_random_phases();
        test_backpressure();
        drain();
        @(negedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== fifo_slot_cache_map_core.f =====
sv/fscm_pkg.sv
sv/fscm_ram.sv
sv/fscm_victim.sv
sv/fifo_slot_cache_map_core.sv
tb/tb.sv
